// ----- hdl/fcrc_pkg.sv -----
package fcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [15:0] BYTE_MASK = 16'h00ff;

    // Register indexes of the configuration channel
    localparam logic [1:0] REG_REGION_START  = 2'd0;
    localparam logic [1:0] REG_REGION_END    = 2'd1;
    localparam logic [1:0] REG_CRC_MSB_FIRST = 2'd2;

    typedef enum logic [1:0] {
        STATUS_PASS      = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_MISMATCH  = 2'd2,
        STATUS_BAD_CFG   = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] region_start;
        logic [15:0] region_end;
        logic        crc_msb_first;
    } cfg_t;

    typedef struct packed {
        logic        frame_pass;
        status_t     check_status;
        logic [15:0] computed_crc;
    } result_t;

    // One byte of CRC-16/XMODEM, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/fcrc_cfg_regs.sv -----
module fcrc_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output fcrc_pkg::cfg_t     cfg
);

    fcrc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Update the addressed register; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.region_start  <= 16'd0;
            cfg_reg.region_end    <= 16'd1;
            cfg_reg.crc_msb_first <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                fcrc_pkg::REG_REGION_START:  cfg_reg.region_start  <= cfg_data;
                fcrc_pkg::REG_REGION_END:    cfg_reg.region_end    <= cfg_data;
                fcrc_pkg::REG_CRC_MSB_FIRST: cfg_reg.crc_msb_first <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/fcrc_frame_track.sv -----
module fcrc_frame_track #(
    parameter int POSITION_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                frame_last,
    input  fcrc_pkg::cfg_t      cfg,
    output fcrc_pkg::result_t   result
);

    localparam int CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0]              crc_reg, crc_next;
    logic [15:0]              rcv_reg, rcv_next;

    logic [POSITION_BITS-1:0] len;
    logic [15:0]              crc_upd, rcv_upd;
    logic [CW-1:0]            pos_ext, len_ext, start_ext, end_ext;
    fcrc_pkg::status_t        status;

    assign pos_ext   = CW'(pos_reg);
    assign len_ext   = CW'(len);
    assign start_ext = CW'(cfg.region_start);
    assign end_ext   = CW'(cfg.region_end);

    // Fold in-region bytes into the CRC and capture received CRC bytes unless saturated
    always_comb begin
        crc_upd = crc_reg;
        rcv_upd = rcv_reg;
        len     = pos_reg;
        if (!(&pos_reg)) begin
            if (pos_ext >= start_ext && pos_ext < end_ext) begin
                crc_upd = fcrc_pkg::crc16_byte(crc_reg, data_byte);
            end
            if (pos_ext == end_ext) begin
                if (cfg.crc_msb_first) rcv_upd = {data_byte, rcv_reg[7:0]};
                else                   rcv_upd = {rcv_reg[15:8], data_byte};
            end else if (pos_ext == end_ext + CW'(1)) begin
                if (cfg.crc_msb_first) rcv_upd = {rcv_reg[15:8], data_byte};
                else                   rcv_upd = {data_byte, rcv_reg[7:0]};
            end
            len = pos_reg + POSITION_BITS'(1);
        end
    end

    // Judge the frame; configuration is checked first
    always_comb begin
        if (start_ext >= end_ext) begin
            status = fcrc_pkg::STATUS_BAD_CFG;
        end else if (len_ext <= start_ext || len_ext < end_ext + CW'(2)) begin
            status = fcrc_pkg::STATUS_SHORT;
        end else if (rcv_upd != crc_upd) begin
            status = fcrc_pkg::STATUS_MISMATCH;
        end else begin
            status = fcrc_pkg::STATUS_PASS;
        end
        result.frame_pass   = (status == fcrc_pkg::STATUS_PASS);
        result.check_status = status;
        result.computed_crc = (status == fcrc_pkg::STATUS_BAD_CFG) ? 16'h0000 : crc_upd;
    end

    // Advance frame state; clear it after the last byte
    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        rcv_next = rcv_reg;
        if (accept) begin
            if (frame_last) begin
                pos_next = '0;
                crc_next = 16'h0000;
                rcv_next = 16'h0000;
            end else begin
                pos_next = len;
                crc_next = crc_upd;
                rcv_next = rcv_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= 16'h0000;
            rcv_reg <= 16'h0000;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            rcv_reg <= rcv_next;
        end
    end

endmodule

// ----- hdl/fcrc_out_reg.sv -----
module fcrc_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  fcrc_pkg::result_t  result,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output fcrc_pkg::result_t  m_result
);

    logic              valid_reg, valid_next;
    fcrc_pkg::result_t data_reg;

    // Accept a new transaction when empty or while the held one is being taken
    assign room     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new result is loaded
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// ----- hdl/frame_crc16_region_check.sv -----
// Channel  | Direction | Payload
// ---------+-----------+---------------------------------------------------
// s_       | in        | tdata[7:0] data_byte, tlast frame_last
// m_       | out       | tdata[15:0] computed_crc, tuser[0] frame_pass,
//          |           | tuser[2:1] check_status
// cfg_     | in        | index 0 region_start, 1 region_end, 2 crc_msb_first
//
// One byte is taken every cycle while the output register has room; the frame
// tracker folds the CRC in byte-wide steps.
// A frame's result appears in the output register in the cycle after its last byte.
// A stalled result holds the output register and input stalls only while it is full
// and not being taken. Reset is synchronous, active low, and clears frame state.
module frame_crc16_region_check #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] computed_crc
    output logic [2:0]  m_tuser,   // [0] frame_pass, [2:1] check_status
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fcrc_pkg::cfg_t    cfg;
    fcrc_pkg::result_t result;
    fcrc_pkg::result_t m_result;
    logic              accept;
    logic              room;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    fcrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcrc_frame_track #(
        .POSITION_BITS (POSITION_BITS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata),
        .frame_last (s_tlast),
        .cfg        (cfg),
        .result     (result)
    );

    fcrc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && s_tlast),
        .result   (result),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // Pack result fields onto the stream
    assign m_tdata = m_result.computed_crc;
    assign m_tuser = {m_result.check_status, m_result.frame_pass};

endmodule

// ----- dv/crc_region_monitor.sv -----
module crc_region_monitor #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] computed_crc
    input  logic [2:0]  m_tuser,   // [0] frame_pass, [2:1] check_status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned LEN_CEILING = (64'd1 << POSITION_BITS) - 64'd1;

    // Verdicts predicted for frames whose last byte went in, oldest first
    fcrc_pkg::result_t verdict_q[$];

    // Local copy of the region registers and of the frame state
    int unsigned     win_start;
    int unsigned     win_end;
    logic            msb_first;
    longint unsigned frame_len;
    logic [15:0]     crc_acc;
    logic [15:0]     rx_crc;
    int              fail_count;
    int              seen_count;

    // Shift one byte into an XMODEM CRC, one bit at a time
    function automatic logic [15:0] crc16_advance(input logic [15:0] crc,
                                                  input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[i]) ? fcrc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    always @(posedge aclk) begin : track
        fcrc_pkg::result_t want;
        fcrc_pkg::result_t got;
        longint unsigned   pos;
        fcrc_pkg::status_t st;
        logic [15:0]       crc_rep;

        if (!aresetn) begin
            win_start = 0;
            win_end = 1;
            msb_first = 1'b0;
            frame_len = 0;
            crc_acc = 16'h0000;
            rx_crc = 16'h0000;
            fail_count = 0;
            seen_count = 0;
            verdict_q.delete();
        end else begin
            // Compare each result transaction with the oldest verdict
            if (m_tvalid && m_tready) begin
                seen_count++;
                got.frame_pass = m_tuser[0];
                got.check_status = fcrc_pkg::status_t'(m_tuser[2:1]);
                got.computed_crc = m_tdata;
                if (verdict_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result with no frame pending: %s%b %s%0d %s%04h",
                                 $realtime, "pass=", m_tuser[0], "status=", m_tuser[2:1],
                                 "crc=", m_tdata);
                    end
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("%0t: verdict differs: pass exp %b got %b,",
                                     $realtime, want.frame_pass, got.frame_pass);
                            $display("    status exp %0d got %0d, crc exp %04h got %04h",
                                     want.check_status, m_tuser[2:1],
                                     want.computed_crc, got.computed_crc);
                        end
                        fail_count++;
                    end
                end
            end

            // Advance the frame state on each byte transaction
            if (s_tvalid && s_tready) begin
                pos = frame_len;
                if (pos < LEN_CEILING) begin
                    if (pos >= win_start && pos < win_end) begin
                        crc_acc = crc16_advance(crc_acc, s_tdata);
                    end
                    if (pos == win_end) begin
                        rx_crc = msb_first ? {s_tdata, rx_crc[7:0]} : {rx_crc[15:8], s_tdata};
                    end else if (pos == win_end + 1) begin
                        rx_crc = msb_first ? {rx_crc[15:8], s_tdata} : {s_tdata, rx_crc[7:0]};
                    end
                    frame_len = pos + 1;
                end
                if (s_tlast) begin
                    crc_rep = crc_acc;
                    if (win_start >= win_end) begin
                        st = fcrc_pkg::STATUS_BAD_CFG;
                        crc_rep = 16'h0000;
                    end else if (frame_len <= win_start || frame_len < win_end + 2) begin
                        st = fcrc_pkg::STATUS_SHORT;
                    end else if (rx_crc != crc_acc) begin
                        st = fcrc_pkg::STATUS_MISMATCH;
                    end else begin
                        st = fcrc_pkg::STATUS_PASS;
                    end
                    want.frame_pass = (st == fcrc_pkg::STATUS_PASS);
                    want.check_status = st;
                    want.computed_crc = crc_rep;
                    verdict_q.push_back(want);
                    frame_len = 0;
                    crc_acc = 16'h0000;
                    rx_crc = 16'h0000;
                end
            end

            // Mirror register writes; they apply from the next byte on
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fcrc_pkg::REG_REGION_START:  win_start = 32'(cfg_data);
                    fcrc_pkg::REG_REGION_END:    win_end = 32'(cfg_data);
                    fcrc_pkg::REG_CRC_MSB_FIRST: msb_first = cfg_data[0];
                    default: ;
                endcase
            end
        end
        mismatches <= fail_count;
        outstanding <= verdict_q.size();
        results_seen <= seen_count;
    end

endmodule

// ----- dv/tb_frame_crc16_region_check.sv -----
module tb_frame_crc16_region_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] computed_crc
    logic [2:0]  m_tuser;           // [0] frame_pass, [2:1] check_status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = fcrc_pkg::REG_REGION_START;
    logic [15:0] cfg_data = 16'h0000;

    int mismatches;
    int pending_results;
    int results_checked;

    // Sender bookkeeping and the region currently programmed
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          settings_used = 0;
    int          idle_cycles = 0;
    int unsigned cur_start = 0;
    int unsigned cur_end = 1;
    logic        cur_msb = 1'b0;

    frame_crc16_region_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crc_region_monitor #(.POSITION_BITS(16)) verdict_mon (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (pending_results),
        .results_seen (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Stop when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("[frame_crc16_region_check] ERROR");
                $finish;
            end
        end
    end

    // Result side: stall in modes that change every so often
    initial begin : sink_stall
        int mode;
        int span;
        forever begin
            mode = int'($urandom_range(0, 3));
            span = int'($urandom_range(20, 200));
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Send one byte transaction; bursts of random length with random gaps
    task automatic put_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                                     : int'($urandom_range(1, 24));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (l) begin
            frames_sent++;
        end
    endtask

    // Send a frame of random bytes carrying the CRC of the current region,
    // optionally with a damaged CRC byte
    task automatic send_frame(input int unsigned len, input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  b;
        logic [7:0]  flip;
        crc = 16'h0000;
        flip = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
        for (int unsigned p = 0; p < len; p++) begin
            b = 8'($urandom_range(0, 255));
            if (p == cur_end) begin
                b = (cur_msb ? crc[15:8] : crc[7:0]) ^ flip;
            end else if (p == cur_end + 1) begin
                b = cur_msb ? crc[7:0] : crc[15:8];
            end
            if (p >= cur_start && p < cur_end) begin
                for (int k = 7; k >= 0; k--) begin
                    crc = {crc[14:0], 1'b0} ^
                          ((crc[15] ^ b[k]) ? fcrc_pkg::CRC_POLY : 16'h0000);
                end
            end
            put_byte(b, p == len - 1);
        end
    endtask

    // Hold the sender until every verdict is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Program all three registers while the block is idle
    task automatic set_region(input logic [15:0] start_pos, input logic [15:0] end_pos,
                              input logic msb_first);
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            case (i)
                0: begin
                    cfg_index <= fcrc_pkg::REG_REGION_START;
                    cfg_data <= start_pos;
                end
                1: begin
                    cfg_index <= fcrc_pkg::REG_REGION_END;
                    cfg_data <= end_pos;
                end
                default: begin
                    cfg_index <= fcrc_pkg::REG_CRC_MSB_FIRST;
                    cfg_data <= {15'($urandom_range(0, 32767)), msb_first};
                end
            endcase
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_start = 32'(start_pos);
        cur_end = 32'(end_pos);
        cur_msb = msb_first;
        settings_used++;
    endtask

    initial begin : stimulus
        int          bytes_goal;
        int          pick;
        int unsigned st;
        int unsigned en;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset region, good frame, single-byte frame, extreme bytes
        send_frame(3, 1'b0);
        send_frame(1, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b1);

        // Directed: high byte first, good and damaged CRC
        set_region(16'd1, 16'd3, 1'b1);
        send_frame(5, 1'b0);
        send_frame(5, 1'b1);

        // Directed: an empty region, and an inverted region at the register extremes
        set_region(16'd7, 16'd7, 1'b0);
        send_frame(2, 1'b0);
        set_region(16'hffff, 16'h0000, 1'b1);
        send_frame(1, 1'b0);

        // Random phases: mostly well-formed frames, some noise
        bytes_goal = bytes_sent + 380;
        while (bytes_sent < bytes_goal) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 6) begin
                st = $urandom_range(0, 6);
                en = st + $urandom_range(1, 10);
            end else if (pick < 8) begin
                st = $urandom_range(0, 12);
                en = $urandom_range(0, st);
            end else if (pick == 8) begin
                st = $urandom_range(0, 65535);
                en = $urandom_range(0, 65535);
            end else begin
                st = 32'hfffe;
                en = 32'hffff;
            end
            set_region(st[15:0], en[15:0], 1'($urandom_range(0, 1)));
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 9) < 7 && cur_end < 64) begin
                    send_frame(cur_end + 2 + $urandom_range(0, 4),
                               $urandom_range(0, 4) == 0);
                end else begin
                    send_frame($urandom_range(1, 12), 1'($urandom_range(0, 1)));
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);

        $display("Drove %0d bytes in %0d frames over %0d region settings",
                 bytes_sent, frames_sent, settings_used);
        $display("Checked %0d verdicts, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_results == 0) begin
            $display("[frame_crc16_region_check] OK");
        end else begin
            if (pending_results != 0) begin
                $display("%0d verdicts never arrived", pending_results);
            end
            $display("[frame_crc16_region_check] ERROR");
        end
        $finish;
    end

endmodule
